[design/ipv6ehs_pkg.sv]
// Shared types, header type codes and helpers for the IPv6 extension header skipper.
package ipv6ehs_pkg;

  // Next-header codes of the extension headers that are walked
  localparam logic [7:0] NH_HOP      = 8'd0;
  localparam logic [7:0] NH_ROUTING  = 8'd43;
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_AUTH     = 8'd51;
  localparam logic [7:0] NH_NONE     = 8'd59;
  localparam logic [7:0] NH_DEST     = 8'd60;

  // Width of the reported header offset
  localparam int unsigned OFFSET_W = 17;

  // Header length in bytes fits in 12 bits: at most 256 * 8
  localparam int unsigned HLEN_W = 12;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // One result word
  typedef struct packed {
    status_t               status;
    logic [7:0]            upper_protocol;
    logic [OFFSET_W-1:0]   header_offset;
  } result_t;

  // True for header types that belong to the extension chain
  function automatic logic is_ext(input logic [7:0] t);
    is_ext = (t == NH_HOP) || (t == NH_ROUTING) || (t == NH_FRAGMENT) ||
             (t == NH_AUTH) || (t == NH_NONE) || (t == NH_DEST);
  endfunction

endpackage

[design/ipv6ehs_walk.sv]
// Per-byte extension header chain walker: walk state and the decision logic.
module ipv6ehs_walk #(
  parameter int unsigned POS_W   = 17,
  parameter int unsigned CAP_VAL = 67583
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    first_byte,
  input  logic [7:0]              initial_nh,
  input  logic                    last_byte,
  output logic                    res_valid,
  output ipv6ehs_pkg::result_t    res
);

  localparam logic [POS_W-1:0] CAP = POS_W'(CAP_VAL);

  // Walk state
  logic [POS_W-1:0]                    pos_r, pos_nxt;
  logic [POS_W-1:0]                    hs_r, hs_nxt;
  logic [7:0]                          cur_r, cur_nxt;
  logic [7:0]                          fol_r, fol_nxt;
  logic [ipv6ehs_pkg::HLEN_W-1:0]      hb_r, hb_nxt;
  logic [7:0]                          ohb_r, ohb_nxt;
  logic                                dec_r, dec_nxt;

  // State as seen by this byte (first byte restarts the walk)
  logic [POS_W-1:0]                    pos_e, hs_e;
  logic [7:0]                          cur_e, fol_e, ohb_e;
  logic [ipv6ehs_pkg::HLEN_W-1:0]      hb_e;
  logic                                dec_e;

  logic [POS_W-1:0]                    diff;
  logic                                in_hdr;
  logic [1:0]                          off;
  logic                                do_adv;
  logic [POS_W:0]                      hs_sum;
  logic [POS_W-1:0]                    hs_adv;
  logic [ipv6ehs_pkg::HLEN_W-1:0]      hb_len;
  logic [ipv6ehs_pkg::HLEN_W-1:0]      hb_step;

  assign pos_e = first_byte ? '0 : pos_r;
  assign hs_e  = first_byte ? '0 : hs_r;
  assign cur_e = first_byte ? initial_nh : cur_r;
  assign fol_e = first_byte ? 8'd0 : fol_r;
  assign hb_e  = first_byte ? '0 : hb_r;
  assign ohb_e = first_byte ? 8'd0 : ohb_r;
  assign dec_e = first_byte ? 1'b0 : dec_r;

  // Position of this byte relative to the current header
  assign diff   = pos_e - hs_e;
  assign in_hdr = (pos_e >= hs_e) && (diff <= POS_W'(3));
  assign off    = diff[1:0];

  // Length of the current header from its length byte
  always_comb begin
    if (cur_e == ipv6ehs_pkg::NH_AUTH) begin
      hb_len = (ipv6ehs_pkg::HLEN_W'(data_byte) + ipv6ehs_pkg::HLEN_W'(2)) << 2;
    end else begin
      hb_len = (ipv6ehs_pkg::HLEN_W'(data_byte) + ipv6ehs_pkg::HLEN_W'(1)) << 3;
    end
  end

  // Bytes to step over: a fragment header is always 8 bytes
  assign hb_step = (cur_e == ipv6ehs_pkg::NH_FRAGMENT) ? ipv6ehs_pkg::HLEN_W'(8) : hb_len;

  // Start of the next header, saturated
  assign hs_sum = (POS_W+1)'(hs_e) + (POS_W+1)'(hb_step);
  assign hs_adv = (hs_sum > {1'b0, CAP}) ? CAP : hs_sum[POS_W-1:0];

  // Decision logic
  always_comb begin
    pos_nxt   = (pos_e == CAP) ? CAP : pos_e + POS_W'(1);
    hs_nxt    = hs_e;
    cur_nxt   = cur_e;
    fol_nxt   = fol_e;
    hb_nxt    = hb_e;
    ohb_nxt   = ohb_e;
    dec_nxt   = dec_e;
    do_adv    = 1'b0;
    res_valid = 1'b0;
    res       = '{status: ipv6ehs_pkg::ST_FOUND, upper_protocol: 8'd0, header_offset: '0};

    if (!dec_e) begin
      if (first_byte && !ipv6ehs_pkg::is_ext(cur_e)) begin
        // upper header right after the base header
        res_valid          = 1'b1;
        res.upper_protocol = cur_e;
      end else if (!in_hdr) begin
        // inside a header body: only the end of data matters
        if (last_byte) begin
          res_valid  = 1'b1;
          res.status = ipv6ehs_pkg::ST_TRUNC;
        end
      end else if (off == 2'd0) begin
        if (last_byte) begin
          res_valid  = 1'b1;
          res.status = ipv6ehs_pkg::ST_TRUNC;
        end else if (cur_e == ipv6ehs_pkg::NH_NONE) begin
          res_valid  = 1'b1;
          res.status = ipv6ehs_pkg::ST_NONE;
        end else begin
          fol_nxt = data_byte;
        end
      end else if (cur_e != ipv6ehs_pkg::NH_FRAGMENT) begin
        if (off != 2'd1) begin
          if (last_byte) begin
            res_valid  = 1'b1;
            res.status = ipv6ehs_pkg::ST_TRUNC;
          end
        end else begin
          hb_nxt = hb_len;
          do_adv = 1'b1;
        end
      end else begin
        // fragment header: offset field in bytes 2 and 3
        if (off == 2'd1) begin
          if (last_byte) begin
            res_valid  = 1'b1;
            res.status = ipv6ehs_pkg::ST_TRUNC;
          end
        end else if (off == 2'd2) begin
          ohb_nxt = data_byte;
          if (last_byte) begin
            res_valid  = 1'b1;
            res.status = ipv6ehs_pkg::ST_TRUNC;
          end
        end else if ((ohb_e != 8'd0) || (data_byte[7:3] != 5'd0)) begin
          // non-first fragment: report the fragment header itself
          res_valid          = 1'b1;
          res.upper_protocol = ipv6ehs_pkg::NH_FRAGMENT;
          res.header_offset  = ipv6ehs_pkg::OFFSET_W'(hs_e);
        end else begin
          hb_nxt = ipv6ehs_pkg::HLEN_W'(8);
          do_adv = 1'b1;
        end
      end

      // step past the current header
      if (do_adv) begin
        hs_nxt = hs_adv;
        if (!ipv6ehs_pkg::is_ext(fol_e)) begin
          res_valid          = 1'b1;
          res.upper_protocol = fol_e;
          res.header_offset  = ipv6ehs_pkg::OFFSET_W'(hs_adv);
        end else begin
          cur_nxt = fol_e;
          if (last_byte) begin
            res_valid  = 1'b1;
            res.status = ipv6ehs_pkg::ST_TRUNC;
          end
        end
      end

      if (res_valid) begin
        dec_nxt = 1'b1;
      end
    end
  end

  // State registers, updated on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hs_r  <= '0;
      cur_r <= 8'd0;
      fol_r <= 8'd0;
      hb_r  <= '0;
      ohb_r <= 8'd0;
      dec_r <= 1'b0;
    end else if (step) begin
      pos_r <= pos_nxt;
      hs_r  <= hs_nxt;
      cur_r <= cur_nxt;
      fol_r <= fol_nxt;
      hb_r  <= hb_nxt;
      ohb_r <= ohb_nxt;
      dec_r <= dec_nxt;
    end
  end

endmodule

[design/ipv6_extension_header_skipper_unit.sv]
// Top level: stream ports, walker and result register of the extension header skipper.
// Latency: a result word is valid on the cycle after the byte that decides it is accepted.
// Throughput: one byte per cycle while no result waits untaken; the walker state updates on each accepted byte,
// and the result register lets a new byte in while the previous result is being taken.
// Reset (synchronous, rst_n low): walk state clears as if a region began at offset 0
// with a hop-by-hop header next; the result register is emptied.
module ipv6_extension_header_skipper_unit #(
  parameter int unsigned MAX_REGION_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] initial_next_header
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [9:2] upper_protocol, [26:10] header_offset
);

  localparam int unsigned CAP_VAL = MAX_REGION_BYTES + 2048;
  localparam int unsigned POS_W   = $clog2(CAP_VAL + 1);

  logic                  in_acc;
  logic                  res_valid;
  ipv6ehs_pkg::result_t  res;
  ipv6ehs_pkg::result_t  out_res_r;
  logic                  out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ipv6ehs_walk #(
    .POS_W   (POS_W),
    .CAP_VAL (CAP_VAL)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .data_byte  (in_tdata[7:0]),
    .first_byte (in_tuser),
    .initial_nh (in_tdata[15:8]),
    .last_byte  (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.header_offset, out_res_r.upper_protocol,
                       out_res_r.status};

  // Input stalls only while a result waits
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with empty result register");

  // Status code is always a defined one
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status == ipv6ehs_pkg::ST_FOUND ||
                     out_res_r.status == ipv6ehs_pkg::ST_NONE ||
                     out_res_r.status == ipv6ehs_pkg::ST_TRUNC))
    else $error("undefined status code");

  // Non-found results carry zero protocol and offset
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ipv6ehs_pkg::ST_FOUND |->
      out_res_r.upper_protocol == 8'd0 && out_res_r.header_offset == '0)
    else $error("nonzero fields on non-found result");

  // A stalled result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result lost");

endmodule

[tb/testbench.sv]
// Self-checking stream testbench for the IPv6 extension header skipper.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned REGION_MAX = 65535;
  // Position and header start stop counting here
  localparam logic [16:0] POS_CAP = 17'(REGION_MAX + 2048);

  // One input word as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic [7:0] nh;
    logic       last;
  } stream_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] data_byte, [15:8] initial_next_header
  logic        in_tuser = 1'b0; // [0] first_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [1:0] status, [9:2] upper_protocol, [26:10] header_offset

  stream_word_t          tx_bytes[$];
  ipv6ehs_pkg::result_t  chain_verdicts[$];
  ipv6ehs_pkg::result_t  seen_verdict;
  stream_word_t          next_word;

  // Walk state of the predictor
  logic [16:0] walk_pos = '0;
  logic [16:0] walk_hdr_start = '0;
  logic [7:0]  walk_cur = ipv6ehs_pkg::NH_HOP;
  logic [7:0]  walk_next = '0;
  logic [11:0] walk_hdr_len = '0;
  logic [7:0]  walk_frag_hi = '0;
  bit          walk_done = 1'b0;

  int  fail_count = 0;
  int  words_in = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  held = 1'b0;
  int  ready_cycles = 0;
  int  cycles = 0;
  int  cycle_limit = 0;
  int  random_words;
  int  pushed;

  ipv6_extension_header_skipper_unit #(
    .MAX_REGION_BYTES(REGION_MAX)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Types that belong to the extension chain
  function automatic bit chain_type(input logic [7:0] t);
    case (t)
      ipv6ehs_pkg::NH_HOP, ipv6ehs_pkg::NH_ROUTING, ipv6ehs_pkg::NH_FRAGMENT,
      ipv6ehs_pkg::NH_AUTH, ipv6ehs_pkg::NH_NONE, ipv6ehs_pkg::NH_DEST: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [16:0] cap_add(input logic [16:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, POS_CAP}) ? POS_CAP : s[16:0];
  endfunction

  task automatic record_verdict(input ipv6ehs_pkg::status_t st, input logic [7:0] proto,
                                input logic [16:0] off);
    ipv6ehs_pkg::result_t r;
    r.status = st;
    r.upper_protocol = proto;
    r.header_offset = off;
    chain_verdicts.push_back(r);
    walk_done = 1'b1;
  endtask

  // Step over the current header, then report or go on with the next type
  task automatic skip_header(input bit last);
    walk_hdr_start = cap_add(walk_hdr_start, {5'd0, walk_hdr_len});
    if (!chain_type(walk_next)) begin
      record_verdict(ipv6ehs_pkg::ST_FOUND, walk_next, walk_hdr_start);
    end else begin
      walk_cur = walk_next;
      if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
    end
  endtask

  // Predict the effect of one accepted byte
  task automatic walk_byte(input logic [7:0] b, input bit first, input logic [7:0] nh,
                           input bit last);
    logic [16:0] p;
    logic [16:0] off;
    if (first) begin
      walk_pos = '0;
      walk_hdr_start = '0;
      walk_cur = nh;
      walk_next = '0;
      walk_hdr_len = '0;
      walk_frag_hi = '0;
      walk_done = 1'b0;
    end
    p = walk_pos;
    walk_pos = cap_add(p, 17'd1);
    if (walk_done) return;
    if (first && !chain_type(walk_cur)) begin
      record_verdict(ipv6ehs_pkg::ST_FOUND, walk_cur, 17'd0);
      return;
    end
    // outside the two type/length bytes and the fragment offset field
    if (p < walk_hdr_start || p - walk_hdr_start > 17'd3) begin
      if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
      return;
    end
    off = p - walk_hdr_start;
    if (off == 17'd0) begin
      if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
      else if (walk_cur == ipv6ehs_pkg::NH_NONE)
        record_verdict(ipv6ehs_pkg::ST_NONE, 8'd0, 17'd0);
      else walk_next = b;
      return;
    end
    if (walk_cur != ipv6ehs_pkg::NH_FRAGMENT) begin
      if (off != 17'd1) begin
        if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
        return;
      end
      // auth counts 4-byte units, the others 8-byte units
      if (walk_cur == ipv6ehs_pkg::NH_AUTH) walk_hdr_len = ({4'd0, b} + 12'd2) << 2;
      else walk_hdr_len = ({4'd0, b} + 12'd1) << 3;
      skip_header(last);
      return;
    end
    // fragment header
    if (off == 17'd1) begin
      if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
      return;
    end
    if (off == 17'd2) begin
      walk_frag_hi = b;
      if (last) record_verdict(ipv6ehs_pkg::ST_TRUNC, 8'd0, 17'd0);
      return;
    end
    if (walk_frag_hi != 8'd0 || (b & 8'hF8) != 8'd0) begin
      record_verdict(ipv6ehs_pkg::ST_FOUND, ipv6ehs_pkg::NH_FRAGMENT, walk_hdr_start);
      return;
    end
    walk_hdr_len = 12'd8;
    skip_header(last);
  endtask

  task automatic push_word(input logic [7:0] data, input bit first, input logic [7:0] nh,
                           input bit last);
    stream_word_t w;
    w.data = data;
    w.first = first;
    // the type field is don't-care off the first word, so toggle it freely
    w.nh = first ? nh : 8'($urandom);
    w.last = last;
    tx_bytes.push_back(w);
  endtask

  function automatic logic [7:0] pick_ext_type();
    case ($urandom_range(0, 4))
      0: return ipv6ehs_pkg::NH_HOP;
      1: return ipv6ehs_pkg::NH_ROUTING;
      2: return ipv6ehs_pkg::NH_FRAGMENT;
      3: return ipv6ehs_pkg::NH_AUTH;
      default: return ipv6ehs_pkg::NH_DEST;
    endcase
  endfunction

  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 39) == 0) return 8'($urandom_range(3, 7));
    return 8'($urandom_range(0, 2));
  endfunction

  // A well-formed chain with random content, sometimes cut short
  task automatic queue_packet(output int n);
    logic [7:0] body[$];
    logic [7:0] kinds[$];
    logic [7:0] upper;
    logic [7:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
    int depth;
    int cut;
    bit drop_last;
    body = {};
    kinds = {};
    depth = $urandom_range(0, 4);
    repeat (depth) kinds.push_back(pick_ext_type());
    if ($urandom_range(0, 6) == 0) begin
      kinds.push_back(ipv6ehs_pkg::NH_NONE);
    end else begin
      do upper = 8'($urandom); while (chain_type(upper));
      kinds.push_back(upper);
    end
    for (int i = 0; i < depth; i++) begin
      body.push_back(kinds[i + 1]);
      case (kinds[i])
        ipv6ehs_pkg::NH_FRAGMENT: begin
          body.push_back(8'($urandom));
          if ($urandom_range(0, 6) != 0) begin
            hi = 8'd0;
            lo = 8'($urandom_range(0, 7));
          end else begin
            hi = 8'($urandom);
            lo = 8'($urandom);
            if (hi == 8'd0 && lo[7:3] == 5'd0) lo[3] = 1'b1;
          end
          body.push_back(hi);
          body.push_back(lo);
          repeat (4) body.push_back(8'($urandom));
        end
        ipv6ehs_pkg::NH_AUTH: begin
          len = pick_len();
          body.push_back(len);
          repeat ((int'(len) + 2) * 4 - 2) body.push_back(8'($urandom));
        end
        default: begin
          len = pick_len();
          body.push_back(len);
          repeat ((int'(len) + 1) * 8 - 2) body.push_back(8'($urandom));
        end
      endcase
    end
    repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    if (body.size() == 0) body.push_back(8'($urandom));
    cut = ($urandom_range(0, 9) < 7) ? body.size() : $urandom_range(1, body.size());
    drop_last = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < cut; i++)
      push_word(body[i], i == 0, kinds[0], (i == cut - 1) && !drop_last);
    n = cut;
  endtask

  // Driver: offers queued words, predicts each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        walk_byte(in_tdata[7:0], in_tuser, in_tdata[15:8], in_tlast);
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tx_bytes.size() != 0) begin
          next_word = tx_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {next_word.nh, next_word.data};
          in_tuser <= next_word.first;
          in_tlast <= next_word.last;
          // idle gaps, with gap-free stretches in between
          if (tx_bytes.size() >= 80 && words_in[8:7] != 2'b11 &&
              $urandom_range(0, 9) == 0)
            tx_gap = $urandom_range(1, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side ready: one long hold-off, plus random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      ready_cycles++;
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && ready_cycles == 200) begin
        held = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (tx_bytes.size() >= 80 && ready_cycles[9:8] != 2'b11 &&
                   $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 5);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (chain_verdicts.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        fail_count++;
      end else begin
        seen_verdict = chain_verdicts.pop_front();
        if (out_tdata[1:0] !== seen_verdict.status) begin
          $error("status: expected %0d, actual %0d", seen_verdict.status, out_tdata[1:0]);
          fail_count++;
        end
        if (out_tdata[9:2] !== seen_verdict.upper_protocol) begin
          $error("upper_protocol: expected %0d, actual %0d",
                 seen_verdict.upper_protocol, out_tdata[9:2]);
          fail_count++;
        end
        if (out_tdata[26:10] !== seen_verdict.header_offset) begin
          $error("header_offset: expected %0d, actual %0d",
                 seen_verdict.header_offset, out_tdata[26:10]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // before any first mark: hop-by-hop assumed at offset 0
    push_word(8'd6, 1'b0, 8'd0, 1'b0);
    push_word(8'd0, 1'b0, 8'd0, 1'b0);
    // upper type straight from the base header, single-word region
    push_word(8'd0, 1'b1, 8'd255, 1'b1);
    // no next header
    push_word(8'd255, 1'b1, ipv6ehs_pkg::NH_NONE, 1'b0);
    // no next header with one byte left
    push_word(8'd0, 1'b1, ipv6ehs_pkg::NH_NONE, 1'b1);
    // extension header cut after its first byte
    push_word(8'd17, 1'b1, ipv6ehs_pkg::NH_HOP, 1'b1);
    // upper header known although data ends right here
    push_word(8'd17, 1'b1, ipv6ehs_pkg::NH_HOP, 1'b0);
    push_word(8'd0, 1'b0, 8'd0, 1'b1);
    // auth header at its largest length
    push_word(8'd6, 1'b1, ipv6ehs_pkg::NH_AUTH, 1'b0);
    push_word(8'd255, 1'b0, 8'd0, 1'b0);
    // hop-by-hop header at its largest length
    push_word(8'd17, 1'b1, ipv6ehs_pkg::NH_HOP, 1'b0);
    push_word(8'd255, 1'b0, 8'd0, 1'b0);
    // non-first fragment
    push_word(8'd17, 1'b1, ipv6ehs_pkg::NH_FRAGMENT, 1'b0);
    push_word(8'hFF, 1'b0, 8'd0, 1'b0);
    push_word(8'h00, 1'b0, 8'd0, 1'b0);
    push_word(8'h08, 1'b0, 8'd0, 1'b0);
    // fragment header cut before its offset low byte
    push_word(8'd6, 1'b1, ipv6ehs_pkg::NH_FRAGMENT, 1'b0);
    push_word(8'h00, 1'b0, 8'd0, 1'b0);
    push_word(8'hFF, 1'b0, 8'd0, 1'b1);
    // first fragment with flag bits only is skipped
    push_word(8'd6, 1'b1, ipv6ehs_pkg::NH_FRAGMENT, 1'b0);
    push_word(8'hAA, 1'b0, 8'd0, 1'b0);
    push_word(8'h00, 1'b0, 8'd0, 1'b0);
    push_word(8'h07, 1'b0, 8'd0, 1'b0);
    // data ends inside a skipped routing header
    push_word(ipv6ehs_pkg::NH_DEST, 1'b1, ipv6ehs_pkg::NH_ROUTING, 1'b0);
    push_word(8'h00, 1'b0, 8'd0, 1'b0);
    push_word(8'h55, 1'b0, 8'd0, 1'b0);
    push_word(8'hAA, 1'b0, 8'd0, 1'b1);

    // random part: mostly chains, some noise
    random_words = 0;
    while (random_words < 420) begin
      if ($urandom_range(0, 9) == 0) begin
        pushed = $urandom_range(1, 5);
        repeat (pushed)
          push_word(8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        queue_packet(pushed);
      end
      random_words += pushed;
    end
    cycle_limit = 30 * tx_bytes.size() + 20000;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (tx_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (chain_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && chain_verdicts.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
design/ipv6ehs_pkg.sv
design/ipv6ehs_walk.sv
design/ipv6_extension_header_skipper_unit.sv
tb/testbench.sv
